/* hdl/quad_mesh_strip_index_generator_assert.svh */
// Assertion macros shared by the quad mesh strip index generator.
`ifndef QUAD_MESH_STRIP_INDEX_GENERATOR_ASSERT_SVH
`define QUAD_MESH_STRIP_INDEX_GENERATOR_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define QMSIG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("qmsig assertion failed");

// Antecedent implies consequent in the next cycle.
`define QMSIG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("qmsig assertion failed");

`endif

/* hdl/qmsig_pkg.sv */
// Shared types and constants of the quad mesh strip index generator.
package qmsig_pkg;

	typedef enum logic [1:0] {
		MODE_OVERALL = 2'd0,
		MODE_ROW     = 2'd1,
		MODE_FACE    = 2'd2,
		MODE_VERTEX  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_ROW_SIZE      = 3'd0,
		REG_COL_SIZE      = 3'd1,
		REG_START_OFFSET  = 3'd2,
		REG_MATERIAL_MODE = 3'd3,
		REG_NORMAL_MODE   = 3'd4
	} reg_idx_t;

	localparam logic [10:0] MIN_SIZE       = 11'd2;
	localparam logic [10:0] RESET_ROW_SIZE = 11'd2;
	localparam logic [10:0] RESET_COL_SIZE = 11'd2;

	// Per-vertex control carried from the walk stage into the datapath.
	typedef struct packed {
		logic [9:0]  face;
		logic [9:0]  part;
		logic        strip_begin;
		logic        strip_end;
		logic        mesh_end;
		mode_t       normal_mode;
		mode_t       material_mode;
		logic [19:0] held_normal;
		logic [19:0] held_material;
	} walk_ctl_t;

	typedef struct packed {
		logic [20:0] coord_index;
		logic [19:0] vertex_index;
		logic [19:0] normal_index;
		logic [19:0] material_index;
		logic [9:0]  face_index;
		logic [9:0]  part_index;
		logic        strip_begin;
		logic        strip_end;
		logic        mesh_end;
	} result_t;

endpackage

/* hdl/quad_mesh_strip_index_generator.sv */
// Top level of the quad mesh strip index generator: registers, stages and stream ports.
//
// Every word accepted on the s_ stream produces exactly one vertex word on the m_ stream.
// The input word carries one bit, restart, which sends the walk back to the first vertex
// before that vertex is produced. Vertices come out strip by strip, upper then lower
// vertex for each column, with coordinate, vertex, normal and material indices plus
// face and part indices; m_tuser flags strip begin and strip end, m_tlast marks the
// last vertex of the mesh, after which the walk starts over by itself.
// Throughput is one vertex per cycle while m_tready is high. The walk counters update
// in the accepting cycle; the row multiply and the final adds sit in two further stages,
// so a vertex passes the walk, multiply and add registers in turn before m_tvalid shows it.
// When the receiver holds m_tready low the three stages fill and s_tready drops; it is
// low only while the output word is stalled.
// Reset clears the walk (first vertex next) and loads row_size 2, col_size 2,
// start_offset 0, material binding overall and normal binding per vertex.
// The APB registers lie at byte addresses 0x00 row_size, 0x04 col_size,
// 0x08 start_offset, 0x0C material_mode, 0x10 normal_mode; write them while idle.
module quad_mesh_strip_index_generator
	import qmsig_pkg::*;
#(
	parameter int MAX_ROW_VERTS = 1024,
	parameter int MAX_COL_VERTS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [0] restart, rest zero
	output logic         m_tvalid,
	input  logic         m_tready,
	// [20:0] coord_index, [40:21] vertex_index, [60:41] normal_index,
	// [80:61] material_index, [90:81] face_index, [100:91] part_index, rest zero
	output logic [103:0] m_tdata,
	output logic [1:0]   m_tuser,   // [0] strip_begin, [1] strip_end
	output logic         m_tlast,   // mesh_end
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int RCW = $clog2(MAX_COL_VERTS);
	localparam int CCW = $clog2(MAX_ROW_VERTS);

	logic [10:0] row_size_q, col_size_q, rs, cs;
	logic [19:0] start_offset_q;
	mode_t       material_mode_q, normal_mode_q;
	logic        cfg_wr, v_s1, ready2;
	reg_idx_t    reg_idx;
	logic [RCW:0]   row_s1;
	logic [CCW-1:0] col_s1;
	walk_ctl_t      ctl_s1;
	result_t        res_s3;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_size_q      <= RESET_ROW_SIZE;
			col_size_q      <= RESET_COL_SIZE;
			start_offset_q  <= '0;
			material_mode_q <= MODE_OVERALL;
			normal_mode_q   <= MODE_VERTEX;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROW_SIZE:      row_size_q      <= pwdata[10:0];
				REG_COL_SIZE:      col_size_q      <= pwdata[10:0];
				REG_START_OFFSET:  start_offset_q  <= pwdata[19:0];
				REG_MATERIAL_MODE: material_mode_q <= mode_t'(pwdata[1:0]);
				REG_NORMAL_MODE:   normal_mode_q   <= mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROW_SIZE:      prdata = 32'(row_size_q);
			REG_COL_SIZE:      prdata = 32'(col_size_q);
			REG_START_OFFSET:  prdata = 32'(start_offset_q);
			REG_MATERIAL_MODE: prdata = 32'(material_mode_q);
			REG_NORMAL_MODE:   prdata = 32'(normal_mode_q);
			default:           prdata = '0;
		endcase
	end

	// Sizes outside the supported range are used clamped.
	assign rs = (row_size_q < MIN_SIZE) ? MIN_SIZE :
		(32'(row_size_q) > MAX_ROW_VERTS) ? 11'(MAX_ROW_VERTS) : row_size_q;
	assign cs = (col_size_q < MIN_SIZE) ? MIN_SIZE :
		(32'(col_size_q) > MAX_COL_VERTS) ? 11'(MAX_COL_VERTS) : col_size_q;

	qmsig_walk #(
		.MAX_ROW_VERTS(MAX_ROW_VERTS),
		.MAX_COL_VERTS(MAX_COL_VERTS)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.restart       (s_tdata[0]),
		.rs            (rs),
		.cs            (cs),
		.normal_mode   (normal_mode_q),
		.material_mode (material_mode_q),
		.out_valid     (v_s1),
		.out_ready     (ready2),
		.row_s1        (row_s1),
		.col_s1        (col_s1),
		.ctl_s1        (ctl_s1)
	);

	qmsig_datapath #(
		.MAX_ROW_VERTS(MAX_ROW_VERTS),
		.MAX_COL_VERTS(MAX_COL_VERTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (v_s1),
		.in_ready     (ready2),
		.row_s1       (row_s1),
		.col_s1       (col_s1),
		.ctl_s1       (ctl_s1),
		.rs           (rs),
		.start_offset (start_offset_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.res_s3       (res_s3)
	);

	assign m_tdata = {3'b000, res_s3.part_index, res_s3.face_index, res_s3.material_index,
		res_s3.normal_index, res_s3.vertex_index, res_s3.coord_index};
	assign m_tuser = {res_s3.strip_end, res_s3.strip_begin};
	assign m_tlast = res_s3.mesh_end;

	`include "quad_mesh_strip_index_generator_assert.svh"

	`QMSIG_ASSERT_IMP(a_mesh_end_ends_strip, clk, arst_n, m_tvalid && m_tlast, m_tuser[1])
	`QMSIG_ASSERT_IMP(a_begin_end_apart, clk, arst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
	`QMSIG_ASSERT_IMP(a_stall_only_from_output, clk, arst_n, !s_tready, m_tvalid && !m_tready)
	`QMSIG_ASSERT_NXT(a_out_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

/* hdl/qmsig_walk.sv */
// Walk state of the quad strip traversal and the first pipeline stage.
module qmsig_walk
	import qmsig_pkg::*;
#(
	parameter int MAX_ROW_VERTS = 1024,
	parameter int MAX_COL_VERTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             restart,
	input  logic [10:0]                      rs,
	input  logic [10:0]                      cs,
	input  mode_t                            normal_mode,
	input  mode_t                            material_mode,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [$clog2(MAX_COL_VERTS):0]   row_s1,
	output logic [$clog2(MAX_ROW_VERTS)-1:0] col_s1,
	output walk_ctl_t                        ctl_s1
);

	localparam int RCW = $clog2(MAX_COL_VERTS);
	localparam int CCW = $clog2(MAX_ROW_VERTS);

	logic [RCW-1:0] row_q, row_d, i_c;
	logic [CCW-1:0] col_q, col_d, j_c;
	logic           lower_q, lower_d, lower_c;
	logic [19:0]    nc_q, nc_d, nc_c, mc_q, mc_d, mc_c;
	logic [19:0]    hn_q, hn_d, hn_c, mc_held_c, hm_q, hm_d, hm_c;
	logic [19:0]    hn_sel, hm_sel;
	logic           clr, wrap, accept, v_s1;
	logic           n_adv, m_adv, send_c;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;

	// A position left outside a shrunken mesh restarts the walk like restart does.
	assign clr = restart || (32'(row_q) > 32'(cs) - 32'd2) || (32'(col_q) > 32'(rs) - 32'd1);

	assign i_c       = clr ? '0 : row_q;
	assign j_c       = clr ? '0 : col_q;
	assign lower_c   = clr ? 1'b0 : lower_q;
	assign nc_c      = clr ? '0 : nc_q;
	assign mc_c      = clr ? '0 : mc_q;
	assign hn_c      = clr ? '0 : hn_q;
	assign mc_held_c = clr ? '0 : hm_q;
	assign hm_c      = mc_held_c;

	// The per-face counters also step on column 0, together with the per-row ones.
	assign n_adv  = !lower_c && ((normal_mode == MODE_ROW && j_c == '0) ||
		normal_mode == MODE_FACE);
	assign m_adv  = !lower_c && ((material_mode == MODE_ROW && j_c == '0) ||
		material_mode == MODE_FACE);
	assign hn_sel = n_adv ? nc_c : hn_c;
	assign hm_sel = m_adv ? mc_c : hm_c;
	assign send_c = lower_c && (32'(j_c) == 32'(rs) - 32'd1);

	always_comb begin
		row_d   = i_c;
		col_d   = j_c;
		lower_d = !lower_c;
		nc_d    = n_adv ? nc_c + 20'd1 : nc_c;
		mc_d    = m_adv ? mc_c + 20'd1 : mc_c;
		hn_d    = hn_sel;
		hm_d    = hm_sel;
		wrap    = 1'b0;
		if (lower_c) begin
			if (32'(j_c) + 32'd1 >= 32'(rs)) begin
				col_d = '0;
				row_d = i_c + 1'b1;
				wrap  = (32'(i_c) + 32'd1 >= 32'(cs) - 32'd1);
			end else begin
				col_d = j_c + 1'b1;
			end
		end
		if (wrap) begin
			row_d = '0;
			col_d = '0;
			nc_d  = '0;
			mc_d  = '0;
			hn_d  = '0;
			hm_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			lower_q <= 1'b0;
			nc_q    <= '0;
			mc_q    <= '0;
			hn_q    <= '0;
			hm_q    <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (accept) begin
				row_q   <= row_d;
				col_q   <= col_d;
				lower_q <= lower_d;
				nc_q    <= nc_d;
				mc_q    <= mc_d;
				hn_q    <= hn_d;
				hm_q    <= hm_d;
				v_s1    <= 1'b1;
			end else if (out_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1                  <= (RCW+1)'(i_c) + (RCW+1)'(lower_c);
			col_s1                  <= j_c;
			ctl_s1.face             <= (j_c == '0) ? 10'd0 : 10'(j_c - 1'b1);
			ctl_s1.part             <= 10'(i_c);
			ctl_s1.strip_begin      <= !lower_c && (j_c == '0);
			ctl_s1.strip_end        <= send_c;
			ctl_s1.mesh_end         <= send_c && (32'(i_c) == 32'(cs) - 32'd2);
			ctl_s1.normal_mode      <= normal_mode;
			ctl_s1.material_mode    <= material_mode;
			ctl_s1.held_normal      <= hn_sel;
			ctl_s1.held_material    <= hm_sel;
		end
	end

endmodule

/* hdl/qmsig_datapath.sv */
// Index arithmetic stages: vertex index, then coordinate, normal and material selection.
module qmsig_datapath
	import qmsig_pkg::*;
#(
	parameter int MAX_ROW_VERTS = 1024,
	parameter int MAX_COL_VERTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [$clog2(MAX_COL_VERTS):0]   row_s1,
	input  logic [$clog2(MAX_ROW_VERTS)-1:0] col_s1,
	input  walk_ctl_t                        ctl_s1,
	input  logic [10:0]                      rs,
	input  logic [19:0]                      start_offset,
	output logic                             out_valid,
	input  logic                             out_ready,
	output result_t                          res_s3
);

	localparam int PW = $clog2(MAX_COL_VERTS) + 1 + 11;

	logic        v_s2, v_s3, ready3;
	logic [19:0] vidx_s2;
	walk_ctl_t   ctl_s2;
	logic [PW-1:0] prod;

	assign ready3    = !v_s3 || out_ready;
	assign in_ready  = !v_s2 || ready3;
	assign out_valid = v_s3;
	assign prod      = PW'(row_s1) * PW'(rs);

	function automatic logic [19:0] pick(mode_t mode, logic [19:0] held, logic [19:0] vidx);
		logic [19:0] r;
		unique case (mode)
			MODE_OVERALL: r = '0;
			MODE_VERTEX:  r = vidx;
			MODE_ROW,
			MODE_FACE:    r = held;
			default:      r = '0;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (ready3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vidx_s2 <= 20'(prod + PW'(col_s1));
			ctl_s2  <= ctl_s1;
		end
		if (ready3 && v_s2) begin
			res_s3.coord_index    <= 21'(start_offset) + 21'(vidx_s2);
			res_s3.vertex_index   <= vidx_s2;
			res_s3.normal_index   <= pick(ctl_s2.normal_mode, ctl_s2.held_normal, vidx_s2);
			res_s3.material_index <= pick(ctl_s2.material_mode, ctl_s2.held_material,
				vidx_s2);
			res_s3.face_index     <= ctl_s2.face;
			res_s3.part_index     <= ctl_s2.part;
			res_s3.strip_begin    <= ctl_s2.strip_begin;
			res_s3.strip_end      <= ctl_s2.strip_end;
			res_s3.mesh_end       <= ctl_s2.mesh_end;
		end
	end

endmodule
